// ===== design/wpsm_pkg.sv =====
package wpsm_pkg;

    localparam int BUCKETS_DEF = 30;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_TEST  = 3'd1;
    localparam logic [2:0] OP_IN    = 3'd2;
    localparam logic [2:0] OP_OUT   = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam int          CFG_IDX_W         = 2;
    localparam logic [1:0]  CFG_BUCKET_TICKS  = 2'd0;
    localparam logic [1:0]  CFG_TICKS_PER_SEC = 2'd1;

    localparam logic [31:0] BUCKET_TICKS_RST  = 32'd33333;
    localparam logic [31:0] TICKS_PER_SEC_RST = 32'd1000000;

    // wrap window for sequence numbers: two thirds and one third of the range
    localparam logic [15:0] SEQ_HIGH_THIRD = 16'd43690;
    localparam logic [15:0] SEQ_LOW_THIRD  = 16'd21845;

    typedef struct packed {
        logic [31:0] tested;
        logic [31:0] accepted;
        logic [31:0] in_sum;
        logic [31:0] out_sum;
        logic [31:0] dur;
    } t_bucket;

    typedef enum logic [4:0] {
        S_IDLE, S_REC, S_DIV, S_DUR_RD, S_DUR_WR, S_CNT_RD, S_CNT_WR,
        S_SWEEP, S_SW_END, S_RAT_INIT, S_RAT_DIV, S_MUL0, S_MUL1,
        S_RINIT, S_RDIV, S_RSTORE, S_RESULT
    } t_state;

    typedef struct packed {
        logic accept;
        logic rec_start;
        logic div_bkt_load;
        logic div_step;
        logic rd_cur;
        logic rd_sweep;
        logic wr_dur;
        logic wr_cnt;
        logic rat_init;
        logic mul0;
        logic mul1;
        logic rate_init;
        logic rate_store;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic adv;
        logic div_last;
        logic sweep_last;
        logic lane;
        logic is_test;
        logic out_free;
    } t_status;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ===== design/windowed_packet_stats_monitor_top.sv =====
// Windowed traffic monitor over a ring of time buckets.
// Input channel: i_valid / o_stall with i_operation, i_prev_sequence,
//   i_next_sequence, i_byte_count. An item is taken when i_valid is high
//   and o_stall is low. Ticks never stall the channel.
// Record items (sequence test, inbound, outbound) pass through REC, CNT_RD
//   and CNT_WR, a sequence test then RESULT to load the output register;
//   when the bucket rolls over, the 32-step quotient of elapsed by bucket
//   length and the duration read and write come between REC and CNT_RD. A
//   query walks the BUCKETS entries of the bucket store one per cycle
//   through its single read port, then runs a 16-step ratio divide and two
//   rate passes (multiply states MUL0 and MUL1 plus 32 divide steps each).
// Output channel: o_valid / i_stall. Sequence tests and queries give one
//   item; the output register holds it while i_stall is high, and the next
//   item is already taken meanwhile. A finished item waits for the register.
// Config: i_cfg_valid / o_cfg_ready (always ready), index 0 bucket_ticks,
//   index 1 ticks_per_second; write only while idle.
// Reset (i_rst_n low, synchronous) restores the default registers, stops
//   timing and clears every bucket through its valid bit at once.
module windowed_packet_stats_monitor_top #(
    parameter int BUCKETS = wpsm_pkg::BUCKETS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [2:0]                     i_operation,
    input  logic [15:0]                    i_prev_sequence,
    input  logic [15:0]                    i_next_sequence,
    input  logic [15:0]                    i_byte_count,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_accepted,
    output logic [16:0]                    o_accepted_ratio,
    output logic [31:0]                    o_bytes_in_rate,
    output logic [31:0]                    o_bytes_out_rate,
    output logic                           o_is_stats,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wpsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    wpsm_pkg::t_cmd    cmd;
    wpsm_pkg::t_status stat;

    assign o_cfg_ready = 1'b1;

    // sequencer: states for the steps of record, rollover and query work
    wpsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_stall)
    );

    // bucket store, window sums, shared divider and output register
    wpsm_dp #(
        .BUCKETS (BUCKETS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_prev_sequence  (i_prev_sequence),
        .i_next_sequence  (i_next_sequence),
        .i_byte_count     (i_byte_count),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_accepted       (o_accepted),
        .o_accepted_ratio (o_accepted_ratio),
        .o_bytes_in_rate  (o_bytes_in_rate),
        .o_bytes_out_rate (o_bytes_out_rate),
        .o_is_stats       (o_is_stats)
    );

endmodule

// ===== design/wpsm_ctrl.sv =====
module wpsm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2:0]        i_operation,
    input  wpsm_pkg::t_status i_stat,
    output wpsm_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    wpsm_pkg::t_state r_state, n_state;
    logic accept;

    assign o_busy = (r_state != wpsm_pkg::S_IDLE);
    assign accept = i_valid && (r_state == wpsm_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wpsm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wpsm_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_operation == wpsm_pkg::OP_TEST || i_operation == wpsm_pkg::OP_IN ||
                        i_operation == wpsm_pkg::OP_OUT) begin
                        n_state = wpsm_pkg::S_REC;
                    end else if (i_operation == wpsm_pkg::OP_QUERY) begin
                        n_state = wpsm_pkg::S_SWEEP;
                    end
                end
            end
            wpsm_pkg::S_REC:      n_state = i_stat.adv ? wpsm_pkg::S_DIV : wpsm_pkg::S_CNT_RD;
            wpsm_pkg::S_DIV:      if (i_stat.div_last) n_state = wpsm_pkg::S_DUR_RD;
            wpsm_pkg::S_DUR_RD:   n_state = wpsm_pkg::S_DUR_WR;
            wpsm_pkg::S_DUR_WR:   n_state = wpsm_pkg::S_CNT_RD;
            wpsm_pkg::S_CNT_RD:   n_state = wpsm_pkg::S_CNT_WR;
            wpsm_pkg::S_CNT_WR:   n_state = i_stat.is_test ? wpsm_pkg::S_RESULT : wpsm_pkg::S_IDLE;
            wpsm_pkg::S_SWEEP:    if (i_stat.sweep_last) n_state = wpsm_pkg::S_SW_END;
            wpsm_pkg::S_SW_END:   n_state = wpsm_pkg::S_RAT_INIT;
            wpsm_pkg::S_RAT_INIT: n_state = wpsm_pkg::S_RAT_DIV;
            wpsm_pkg::S_RAT_DIV:  if (i_stat.div_last) n_state = wpsm_pkg::S_MUL0;
            wpsm_pkg::S_MUL0:     n_state = wpsm_pkg::S_MUL1;
            wpsm_pkg::S_MUL1:     n_state = wpsm_pkg::S_RINIT;
            wpsm_pkg::S_RINIT:    n_state = wpsm_pkg::S_RDIV;
            wpsm_pkg::S_RDIV:     if (i_stat.div_last) n_state = wpsm_pkg::S_RSTORE;
            wpsm_pkg::S_RSTORE:   n_state = i_stat.lane ? wpsm_pkg::S_RESULT : wpsm_pkg::S_MUL0;
            wpsm_pkg::S_RESULT:   if (i_stat.out_free) n_state = wpsm_pkg::S_IDLE;
            default:              n_state = wpsm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.accept = accept;
        case (r_state)
            wpsm_pkg::S_REC: begin
                o_cmd.rec_start    = 1'b1;
                o_cmd.div_bkt_load = i_stat.adv;
            end
            wpsm_pkg::S_DIV:      o_cmd.div_step   = 1'b1;
            wpsm_pkg::S_DUR_RD:   o_cmd.rd_cur     = 1'b1;
            wpsm_pkg::S_DUR_WR:   o_cmd.wr_dur     = 1'b1;
            wpsm_pkg::S_CNT_RD:   o_cmd.rd_cur     = 1'b1;
            wpsm_pkg::S_CNT_WR:   o_cmd.wr_cnt     = 1'b1;
            wpsm_pkg::S_SWEEP:    o_cmd.rd_sweep   = 1'b1;
            wpsm_pkg::S_RAT_INIT: o_cmd.rat_init   = 1'b1;
            wpsm_pkg::S_RAT_DIV:  o_cmd.div_step   = 1'b1;
            wpsm_pkg::S_MUL0:     o_cmd.mul0       = 1'b1;
            wpsm_pkg::S_MUL1:     o_cmd.mul1       = 1'b1;
            wpsm_pkg::S_RINIT:    o_cmd.rate_init  = 1'b1;
            wpsm_pkg::S_RDIV:     o_cmd.div_step   = 1'b1;
            wpsm_pkg::S_RSTORE:   o_cmd.rate_store = 1'b1;
            wpsm_pkg::S_RESULT:   o_cmd.out_load   = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

// ===== design/wpsm_dp.sv =====
module wpsm_dp #(
    parameter int BUCKETS = wpsm_pkg::BUCKETS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wpsm_pkg::t_cmd                 i_cmd,
    output wpsm_pkg::t_status              o_stat,
    input  logic [2:0]                     i_operation,
    input  logic [15:0]                    i_prev_sequence,
    input  logic [15:0]                    i_next_sequence,
    input  logic [15:0]                    i_byte_count,
    input  logic                           i_cfg_we,
    input  logic [wpsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic                           o_accepted,
    output logic [16:0]                    o_accepted_ratio,
    output logic [31:0]                    o_bytes_in_rate,
    output logic [31:0]                    o_bytes_out_rate,
    output logic                           o_is_stats
);

    localparam int CW   = $clog2(BUCKETS);
    localparam int SUMW = 32 + CW;          // holds BUCKETS full 32-bit counters

    // configuration and latched item
    logic [31:0] r_bt, r_tps;
    logic [2:0]  r_op;
    logic [15:0] r_prev, r_next, r_bytes;

    // timing state
    logic          r_started;
    logic [31:0]   r_elapsed;
    logic [CW-1:0] r_cur;
    logic          r_vld [BUCKETS];

    // bucket store
    wpsm_pkg::t_bucket r_mem [BUCKETS];
    wpsm_pkg::t_bucket r_rd;
    logic              r_rd_v;
    logic              r_rd_ok;
    logic [CW-1:0]     r_idx;

    // window sums
    logic [SUMW-1:0] r_s_acc, r_s_test, r_s_in, r_s_out, r_s_t;

    // shared restoring divider, also tracks quotient mod BUCKETS
    logic [SUMW:0]   r_rem;
    logic [31:0]     r_dvd;
    logic [SUMW-1:0] r_dvs;
    logic [31:0]     r_q;
    logic [CW-1:0]   r_qm;
    logic [5:0]      r_cnt;

    logic [SUMW+31:0] r_prod;
    logic             r_sat;
    logic             r_lane;
    logic [16:0]      r_ratio;
    logic [31:0]      r_in_rate, r_out_rate;

    logic [31:0]       len;
    logic              seq_acc;
    wpsm_pkg::t_bucket rdw, wr_word;
    logic [SUMW:0]     rem2, rem_n;
    logic              ge;
    logic [CW:0]       qm2, qm_n;
    logic [CW:0]       cur_sum;
    logic [CW-1:0]     cur_n;
    logic [SUMW-1:0]   sel_sum;
    logic [63:0]       p_lo;
    logic [CW+31:0]    p_hi;
    logic [31:0]       rate_val;
    logic              active;
    logic [CW-1:0]     raddr;

    assign len     = (r_bt == 32'd0) ? 32'd1 : r_bt;
    assign seq_acc = (r_next > r_prev) ||
                     (r_prev >= wpsm_pkg::SEQ_HIGH_THIRD && r_next < wpsm_pkg::SEQ_LOW_THIRD);
    assign rdw     = r_rd_v ? r_rd : '0;
    assign active  = (rdw.tested != 32'd0) || (rdw.in_sum != 32'd0) || (rdw.out_sum != 32'd0);

    assign rem2  = {r_rem[SUMW-1:0], r_dvd[31]};
    assign ge    = rem2 >= {1'b0, r_dvs};
    assign rem_n = ge ? rem2 - {1'b0, r_dvs} : rem2;
    assign qm2   = {r_qm, ge};
    assign qm_n  = (qm2 >= (CW+1)'(BUCKETS)) ? qm2 - (CW+1)'(BUCKETS) : qm2;

    assign cur_sum = {1'b0, r_cur} + {1'b0, r_qm};
    assign cur_n   = (cur_sum >= (CW+1)'(BUCKETS)) ? CW'(cur_sum - (CW+1)'(BUCKETS))
                                                   : cur_sum[CW-1:0];

    assign sel_sum = r_lane ? r_s_out : r_s_in;
    assign p_lo    = 64'(sel_sum[31:0]) * 64'(r_tps);
    assign p_hi    = (CW+32)'(sel_sum[SUMW-1:32]) * (CW+32)'(r_tps);

    always_comb begin
        if (r_s_t == '0) begin
            rate_val = (|sel_sum[SUMW-1:32]) ? 32'hFFFF_FFFF : sel_sum[31:0];
        end else if (r_sat) begin
            rate_val = 32'hFFFF_FFFF;
        end else begin
            rate_val = r_q;
        end
    end

    always_comb begin
        wr_word = rdw;
        if (i_cmd.wr_dur) begin
            wr_word.dur = r_elapsed;
        end else begin
            case (r_op)
                wpsm_pkg::OP_TEST: begin
                    wr_word.tested   = wpsm_pkg::sat_add32(rdw.tested, 32'd1);
                    wr_word.accepted = wpsm_pkg::sat_add32(rdw.accepted, {31'd0, seq_acc});
                end
                wpsm_pkg::OP_IN:  wr_word.in_sum  = wpsm_pkg::sat_add32(rdw.in_sum, {16'd0, r_bytes});
                wpsm_pkg::OP_OUT: wr_word.out_sum = wpsm_pkg::sat_add32(rdw.out_sum, {16'd0, r_bytes});
                default: ;
            endcase
        end
    end

    assign raddr = i_cmd.rd_sweep ? r_idx : r_cur;

    assign o_stat.adv        = r_started && (r_elapsed > len);
    assign o_stat.div_last   = (r_cnt == 6'd1);
    assign o_stat.sweep_last = (r_idx == CW'(BUCKETS - 1));
    assign o_stat.lane       = r_lane;
    assign o_stat.is_test    = (r_op == wpsm_pkg::OP_TEST);
    assign o_stat.out_free   = !o_valid || !i_stall;

    // store write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_dur || i_cmd.wr_cnt) begin
            r_mem[r_cur] <= wr_word;
        end
        if (i_cmd.rd_cur || i_cmd.rd_sweep) begin
            r_rd   <= r_mem[raddr];
            r_rd_v <= r_vld[raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bt      <= wpsm_pkg::BUCKET_TICKS_RST;
            r_tps     <= wpsm_pkg::TICKS_PER_SEC_RST;
            r_started <= 1'b0;
            r_elapsed <= 32'd0;
            r_cur     <= '0;
            r_rd_ok   <= 1'b0;
            o_valid   <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wpsm_pkg::CFG_BUCKET_TICKS:  r_bt  <= i_cfg_data;
                    wpsm_pkg::CFG_TICKS_PER_SEC: r_tps <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept && i_operation == wpsm_pkg::OP_TICK && r_started) begin
                r_elapsed <= wpsm_pkg::sat_add32(r_elapsed, 32'd1);
            end
            if (i_cmd.rec_start && !r_started) begin
                r_started <= 1'b1;
                r_elapsed <= 32'd0;
            end
            if (i_cmd.wr_cnt) begin
                r_vld[r_cur] <= 1'b1;
            end
            if (i_cmd.wr_dur) begin
                // close the old bucket, then drop the one we land on
                if (cur_n != r_cur) begin
                    r_vld[r_cur] <= 1'b1;
                end
                r_vld[cur_n] <= 1'b0;
                r_cur        <= cur_n;
                r_elapsed    <= 32'd0;
            end
            r_rd_ok <= i_cmd.rd_sweep;
            if (i_cmd.out_load) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // payload and arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_operation;
            r_prev   <= i_prev_sequence;
            r_next   <= i_next_sequence;
            r_bytes  <= i_byte_count;
            r_idx    <= '0;
            r_lane   <= 1'b0;
            r_s_acc  <= '0;
            r_s_test <= '0;
            r_s_in   <= '0;
            r_s_out  <= '0;
            r_s_t    <= '0;
        end
        if (i_cmd.rd_sweep) begin
            r_idx <= r_idx + CW'(1);
        end
        if (r_rd_ok && active) begin
            r_s_acc  <= r_s_acc  + SUMW'(rdw.accepted);
            r_s_test <= r_s_test + SUMW'(rdw.tested);
            r_s_in   <= r_s_in   + SUMW'(rdw.in_sum);
            r_s_out  <= r_s_out  + SUMW'(rdw.out_sum);
            r_s_t    <= r_s_t    + SUMW'(rdw.dur);
        end
        if (i_cmd.div_bkt_load) begin
            r_rem <= '0;
            r_dvd <= r_elapsed;
            r_dvs <= SUMW'(len);
            r_q   <= 32'd0;
            r_qm  <= '0;
            r_cnt <= 6'd32;
        end else if (i_cmd.rat_init) begin
            // accepted never exceeds tested, so the integer part is 0 or 1
            r_rem <= (r_s_acc >= r_s_test) ? {1'b0, r_s_acc - r_s_test} : {1'b0, r_s_acc};
            r_dvd <= 32'd0;
            r_dvs <= r_s_test;
            r_q   <= {31'd0, r_s_acc >= r_s_test};
            r_qm  <= '0;
            r_cnt <= 6'd16;
        end else if (i_cmd.rate_init) begin
            r_rem <= {1'b0, r_prod[SUMW+31:32]};
            r_dvd <= r_prod[31:0];
            r_dvs <= r_s_t;
            r_q   <= 32'd0;
            r_qm  <= '0;
            r_sat <= r_prod[SUMW+31:32] >= r_s_t;
            r_cnt <= 6'd32;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_n;
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_q   <= {r_q[30:0], ge};
            r_qm  <= qm_n[CW-1:0];
            r_cnt <= r_cnt - 6'd1;
        end
        if (i_cmd.mul0) begin
            r_prod <= (SUMW+32)'(p_lo);
            if (!r_lane) begin
                r_ratio <= (r_s_test == '0) ? 17'd0 : r_q[16:0];
            end
        end
        if (i_cmd.mul1) begin
            r_prod <= r_prod + {p_hi, 32'd0};
        end
        if (i_cmd.rate_store) begin
            if (r_lane) begin
                r_out_rate <= rate_val;
            end else begin
                r_in_rate <= rate_val;
            end
            r_lane <= 1'b1;
        end
        if (i_cmd.out_load) begin
            if (r_op == wpsm_pkg::OP_QUERY) begin
                o_accepted       <= 1'b0;
                o_accepted_ratio <= r_ratio;
                o_bytes_in_rate  <= r_in_rate;
                o_bytes_out_rate <= r_out_rate;
                o_is_stats       <= 1'b1;
            end else begin
                o_accepted       <= seq_acc;
                o_accepted_ratio <= 17'd0;
                o_bytes_in_rate  <= 32'd0;
                o_bytes_out_rate <= 32'd0;
                o_is_stats       <= 1'b0;
            end
        end
    end

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur < CW'(BUCKETS)) else $error("bucket index out of range");

    a_qm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> r_qm < CW'(BUCKETS)) else $error("step residue out of range");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_dur |=> (r_elapsed == 32'd0) && !r_vld[r_cur])
        else $error("landed bucket not cleared");

endmodule
